FILE: hdl/esms_pkg.sv
// esms_pkg: shared types, codes and helpers of the edge speed smoother.
// Used by every module of the block except esms_ram; has no dependencies.
package esms_pkg;

  // field widths
  localparam int EDGE_W  = 10;
  localparam int SPD_W   = 16;
  localparam int LEN_W   = 20;
  localparam int TIME_W  = 24;
  localparam int VAL_W   = 20;
  localparam int STEPS_W = 5;
  localparam int WGT_W   = 17;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 2;
  localparam int DIV_W   = 32;

  // defaults for top level parameters
  localparam int DEF_EDGES     = 1024;
  localparam int DEF_MAX_STEPS = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // register indexes
  localparam logic [CFG_W-1:0] CFG_AVG_STEPS    = 2'd0;
  localparam logic [CFG_W-1:0] CFG_PRIOR_WEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] CFG_MIN_SPEED    = 2'd2;

  localparam logic [WGT_W-1:0]  WGT_ONE  = 17'h10000;
  localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
  localparam logic [SPD_W-1:0]  SPD_MAX  = 16'hFFFF;

  // one classified command as queued between front and back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [EDGE_W-1:0] edge_id;
    logic              hit;       // edge inside the table
    logic [SPD_W-1:0]  speed;
    logic [LEN_W-1:0]  edge_length;
    logic [TIME_W-1:0] min_travel_time;
    logic              end_of_pass;
  } item_t;

  // clamp a wide value to the speed range
  function automatic logic [SPD_W-1:0] sat_speed(input logic [DIV_W-1:0] x);
    logic [SPD_W-1:0] r;
    r = (x > DIV_W'(SPD_MAX)) ? SPD_MAX : x[SPD_W-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/esms_ram.sv
// esms_ram: generic single write port RAM with one registered read port.
// No dependencies.
module esms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/esms_div.sv
// esms_div: serial restoring divider, one quotient bit per cycle.
// Depends on esms_pkg for widths.
module esms_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [esms_pkg::DIV_W-1:0] dividend,
  input  logic [esms_pkg::SPD_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [esms_pkg::DIV_W-1:0] quotient
);

  localparam int CW = $clog2(esms_pkg::DIV_W);

  logic [esms_pkg::SPD_W:0]   rem;
  logic [esms_pkg::SPD_W-1:0] dsr;
  logic [CW-1:0]              cnt;
  logic [esms_pkg::SPD_W:0]   rem_sh;
  logic                       qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem[esms_pkg::SPD_W-1:0], quotient[esms_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(esms_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quotient <= {quotient[esms_pkg::DIV_W-2:0], qbit};
    end
  end

endmodule

FILE: hdl/esms_front.sv
// esms_front: input side; accepts commands, classifies them, queues two.
// Depends on esms_pkg for item_t and widths.
module esms_front #(
  parameter int EDGES = esms_pkg::DEF_EDGES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [esms_pkg::CMD_W-1:0]  cmd,
  input  logic [esms_pkg::EDGE_W-1:0] edge_id,
  input  logic [esms_pkg::SPD_W-1:0]  speed,
  input  logic [esms_pkg::LEN_W-1:0]  edge_length,
  input  logic [esms_pkg::TIME_W-1:0] min_travel_time,
  input  logic                        end_of_pass,
  output esms_pkg::item_t             head,
  output logic                        head_valid,
  input  logic                        pop
);

  esms_pkg::item_t q [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;
  esms_pkg::item_t item_in;

  // classify the incoming transaction
  always_comb begin
    item_in.cmd             = cmd;
    item_in.edge_id         = edge_id;
    item_in.hit             = (32'(edge_id) < EDGES);
    item_in.speed           = speed;
    item_in.edge_length     = edge_length;
    item_in.min_travel_time = min_travel_time;
    item_in.end_of_pass     = end_of_pass;
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head       = q[rptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item_in;
    end
  end

endmodule

FILE: hdl/esms_back.sv
// esms_back: command sequencer with edge value and history memories,
// shared serial divider and output register. Depends on esms_pkg, esms_ram, esms_div.
module esms_back #(
  parameter int EDGES     = esms_pkg::DEF_EDGES,
  parameter int MAX_STEPS = esms_pkg::DEF_MAX_STEPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  esms_pkg::item_t              head,
  input  logic                         head_valid,
  output logic                         pop,
  input  logic [esms_pkg::STEPS_W-1:0] avg_steps,
  input  logic [esms_pkg::WGT_W-1:0]   prior_weight,
  input  logic [esms_pkg::SPD_W-1:0]   min_speed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [esms_pkg::EDGE_W-1:0]  edge_out,
  output logic [esms_pkg::SPD_W-1:0]   smoothed_speed,
  output logic [esms_pkg::TIME_W-1:0]  effort
);

  localparam int EAW = $clog2(EDGES);
  localparam int HD  = EDGES * MAX_STEPS;
  localparam int HAW = $clog2(HD);
  localparam int SW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int NW  = $clog2(MAX_STEPS + 1);
  localparam int PW  = esms_pkg::SPD_W + esms_pkg::WGT_W;
  localparam int VW  = esms_pkg::VAL_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_EXPW   = 4'd5;
  localparam logic [3:0] S_DIV1   = 4'd6;
  localparam logic [3:0] S_ESTART = 4'd7;
  localparam logic [3:0] S_DIV2   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]                  state;
  logic [3:0]                  state_next;
  esms_pkg::item_t             item;
  logic [SW-1:0]               slot_q;
  logic [SW-1:0]               history_slot;
  logic [SW-1:0]               fill_k;
  logic [esms_pkg::SPD_W-1:0]  sp;
  logic [esms_pkg::TIME_W-1:0] eff;
  logic [PW-1:0]               p1;
  logic [PW-1:0]               p2;

  logic [NW-1:0]               n;
  logic                        nz;
  logic [SW-1:0]               slot_cur;
  logic [SW-1:0]               slot_inc;
  logic [esms_pkg::WGT_W-1:0]  w;
  logic [esms_pkg::SPD_W-1:0]  floor_s;
  logic [esms_pkg::SPD_W-1:0]  old_sp;

  logic                        val_we;
  logic [VW-1:0]               val_wdata;
  logic [VW-1:0]               val_rdata;
  logic [EAW-1:0]              val_raddr;
  logic [EAW-1:0]              val_waddr;
  logic                        hist_we;
  logic [HAW-1:0]              hist_waddr;
  logic [HAW-1:0]              hist_raddr;
  logic [esms_pkg::SPD_W-1:0]  hist_rdata;

  logic                        div_start;
  logic [esms_pkg::DIV_W-1:0]  div_a;
  logic [esms_pkg::SPD_W-1:0]  div_b;
  logic                        div_busy;
  logic                        div_done;
  logic [esms_pkg::DIV_W-1:0]  div_q;

  logic signed [VW+1:0]        s_raw;
  logic [VW-1:0]               ssum;
  logic [PW:0]                 acc;
  logic [esms_pkg::TIME_W-1:0] t_sat;
  logic                        out_load;

  // effective configuration
  always_comb begin
    if (32'(avg_steps) > MAX_STEPS) begin
      n = NW'(MAX_STEPS);
    end else begin
      n = NW'(avg_steps);
    end
    nz       = (n != '0);
    slot_cur = (32'(history_slot) < 32'(n)) ? history_slot : '0;
    slot_inc = (32'(slot_q) + 1 == 32'(n)) ? '0 : slot_q + 1'b1;
    w        = (prior_weight > esms_pkg::WGT_ONE) ? esms_pkg::WGT_ONE : prior_weight;
    floor_s  = (min_speed == '0) ? esms_pkg::SPD_W'(1) : min_speed;
    old_sp   = esms_pkg::sat_speed(esms_pkg::DIV_W'(val_rdata));
  end

  // sliding sum update clamped to the value range, EMA rounding sum, time clamp
  always_comb begin
    s_raw = $signed({2'b00, val_rdata}) + $signed((VW+2)'(item.speed))
          - $signed((VW+2)'(hist_rdata));
    if (s_raw < 0) begin
      ssum = '0;
    end else if (s_raw > $signed((VW+2)'({VW{1'b1}}))) begin
      ssum = '1;
    end else begin
      ssum = s_raw[VW-1:0];
    end
    acc   = (PW+1)'(p1) + (PW+1)'(p2) + (PW+1)'(32768);
    t_sat = (div_q > esms_pkg::DIV_W'(esms_pkg::TIME_MAX)) ? esms_pkg::TIME_MAX
          : div_q[esms_pkg::TIME_W-1:0];
  end

  // memory addresses
  assign val_raddr  = EAW'(head.edge_id);
  assign val_waddr  = EAW'(item.edge_id);
  assign hist_raddr = HAW'(EAW'(head.edge_id)) * HAW'(MAX_STEPS) + HAW'(slot_cur);

  // memory writes and divider launch
  always_comb begin
    val_we     = 1'b0;
    val_wdata  = '0;
    hist_we    = 1'b0;
    hist_waddr = HAW'(EAW'(item.edge_id)) * HAW'(MAX_STEPS) + HAW'(slot_q);
    div_start  = 1'b0;
    div_a      = esms_pkg::DIV_W'(val_rdata);
    div_b      = esms_pkg::SPD_W'(n);
    unique case (state)
      S_EXEC: begin
        if (item.hit) begin
          if (item.cmd == esms_pkg::CMD_INIT) begin
            val_we    = 1'b1;
            val_wdata = nz ? VW'(32'(item.speed) * 32'(n)) : VW'(item.speed);
          end else if (item.cmd == esms_pkg::CMD_SAMPLE) begin
            if (nz) begin
              val_we    = 1'b1;
              val_wdata = ssum;
              hist_we   = 1'b1;
              div_start = 1'b1;
              div_a     = esms_pkg::DIV_W'(ssum);
            end
          end else begin
            div_start = nz;
          end
        end
      end
      S_FILL: begin
        hist_we    = 1'b1;
        hist_waddr = HAW'(EAW'(item.edge_id)) * HAW'(MAX_STEPS) + HAW'(fill_k);
      end
      S_EXPW: begin
        val_we    = 1'b1;
        val_wdata = VW'(acc[PW:16]);
      end
      S_ESTART: begin
        div_start = 1'b1;
        div_a     = {item.edge_length, 12'd0};
        div_b     = (sp > floor_s) ? sp : floor_s;
      end
      default: begin
      end
    endcase
  end

  assign pop      = (state == S_IDLE) && head_valid;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (head_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (!item.hit) begin
          state_next = S_DONE;
        end else if (item.cmd == esms_pkg::CMD_INIT) begin
          state_next = S_FILL;
        end else if (item.cmd == esms_pkg::CMD_SAMPLE) begin
          if (nz) begin
            state_next = S_DIV1;
          end else if (item.speed == old_sp) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL1;
          end
        end else if (nz) begin
          state_next = S_DIV1;
        end else if (item.cmd == esms_pkg::CMD_QUERY) begin
          state_next = S_ESTART;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL:   if (32'(fill_k) == MAX_STEPS - 1) state_next = S_DONE;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_EXPW;
      S_EXPW:   state_next = S_DONE;
      S_DIV1: begin
        if (div_done) begin
          state_next = (item.cmd == esms_pkg::CMD_QUERY) ? S_ESTART : S_DONE;
        end
      end
      S_ESTART: state_next = S_DIV2;
      S_DIV2:   if (div_done) state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      history_slot <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && item.cmd == esms_pkg::CMD_SAMPLE && nz
          && item.end_of_pass) begin
        history_slot <= slot_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item   <= head;
      slot_q <= slot_cur;
    end
    unique case (state)
      S_EXEC: begin
        eff    <= '0;
        fill_k <= '0;
        if (!item.hit) begin
          sp <= '0;
        end else if (item.cmd == esms_pkg::CMD_INIT) begin
          sp <= item.speed;
        end else begin
          sp <= old_sp;
        end
      end
      S_FILL:   fill_k <= fill_k + 1'b1;
      S_MUL1:   p1 <= PW'(sp) * PW'(w);
      S_MUL2:   p2 <= PW'(item.speed) * PW'(esms_pkg::WGT_ONE - w);
      S_EXPW:   sp <= acc[31:16];
      S_DIV1:   if (div_done) sp <= esms_pkg::sat_speed(div_q);
      S_DIV2: begin
        if (div_done) begin
          eff <= (t_sat < item.min_travel_time) ? item.min_travel_time : t_sat;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      edge_out       <= item.edge_id;
      smoothed_speed <= sp;
      effort         <= eff;
    end
  end

  esms_ram #(.WIDTH(VW), .DEPTH(EDGES)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  esms_ram #(.WIDTH(esms_pkg::SPD_W), .DEPTH(HD)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (item.speed),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  esms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // checks
  a_done_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !div_busy)
    else $error("divider busy while result is pending");

  a_hist_we_state: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (state == S_EXEC || state == S_FILL))
    else $error("history write outside sample or fill");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (32'(fill_k) < MAX_STEPS))
    else $error("fill index past history depth");

endmodule

FILE: hdl/edge_speed_smoother_top.sv
// edge_speed_smoother_top: top level of the per-edge speed smoother.
// Depends on esms_pkg, esms_front, esms_back (and through it esms_ram, esms_div).
//
// Usage:
//  Command channel: in_valid/in_stall with cmd, edge_id, speed, edge_length,
//  min_travel_time, end_of_pass. A transaction is taken when in_valid is high
//  and in_stall low. A two-entry queue sits behind the port.
//  Result channel: out_valid/out_stall with edge_out, smoothed_speed, effort;
//  one result per command, in order, held steady while out_stall is high.
//  Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data
//  (0 avg_steps, 1 prior_weight, 2 min_speed); cfg_ready is always high.
//  Per command the sequencer uses the serial divider as follows: init needs
//  no division and writes the history one entry per cycle, an EMA sample
//  needs none, a sliding sample or readout and a query in EMA mode need one,
//  a query in sliding mode needs two. Commands are processed one at a time.
//  Reset clears the sequencer, the history slot and the queue; the memories
//  hold no defined value until an edge is initialized. While out_stall is
//  high the finished result waits in the output register and the next
//  command is still taken into the queue and processed up to its result.
module edge_speed_smoother_top #(
  parameter int EDGES     = esms_pkg::DEF_EDGES,
  parameter int MAX_STEPS = esms_pkg::DEF_MAX_STEPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [esms_pkg::CMD_W-1:0]   cmd,
  input  logic [esms_pkg::EDGE_W-1:0]  edge_id,
  input  logic [esms_pkg::SPD_W-1:0]   speed,
  input  logic [esms_pkg::LEN_W-1:0]   edge_length,
  input  logic [esms_pkg::TIME_W-1:0]  min_travel_time,
  input  logic                         end_of_pass,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [esms_pkg::EDGE_W-1:0]  edge_out,
  output logic [esms_pkg::SPD_W-1:0]   smoothed_speed,
  output logic [esms_pkg::TIME_W-1:0]  effort,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [esms_pkg::CFG_W-1:0]   cfg_index,
  input  logic [esms_pkg::WGT_W-1:0]   cfg_data
);

  logic [esms_pkg::STEPS_W-1:0] avg_steps;
  logic [esms_pkg::WGT_W-1:0]   prior_weight;
  logic [esms_pkg::SPD_W-1:0]   min_speed;
  esms_pkg::item_t              head;
  logic                         head_valid;
  logic                         pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_steps    <= '0;
      prior_weight <= 17'd32768;
      min_speed    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        esms_pkg::CFG_AVG_STEPS:    avg_steps    <= cfg_data[esms_pkg::STEPS_W-1:0];
        esms_pkg::CFG_PRIOR_WEIGHT: prior_weight <= cfg_data;
        esms_pkg::CFG_MIN_SPEED:    min_speed    <= cfg_data[esms_pkg::SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  esms_front #(.EDGES(EDGES)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .edge_id         (edge_id),
    .speed           (speed),
    .edge_length     (edge_length),
    .min_travel_time (min_travel_time),
    .end_of_pass     (end_of_pass),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop)
  );

  esms_back #(.EDGES(EDGES), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .avg_steps      (avg_steps),
    .prior_weight   (prior_weight),
    .min_speed      (min_speed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_out       (edge_out),
    .smoothed_speed (smoothed_speed),
    .effort         (effort)
  );

endmodule
